// File: rtl/hvg_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and the controller command struct for the
// Householder vector generator. No dependencies.
package hvg_pkg;

   localparam int ELEM_W   = 24;
   localparam int SQ_W     = 2 * ELEM_W - 1;
   localparam int SUM_W    = 53;
   localparam int RAD_W    = SUM_W + 1;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 1;
   localparam int APM_W    = ROOT_W + 1;
   localparam int DEN_W    = ROOT_W + APM_W;
   localparam int THR_W    = 24;
   localparam int OUT_W    = 28;
   localparam int BETA_W   = 32;
   localparam int NUM_SHIFT = 48;

   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = NUM_SHIFT + 1;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
   // A denominator at or below 2^(NUM_SHIFT-BETA_W) yields a quotient past the beta range.
   localparam logic [DEN_W-1:0] DEN_SAT_LIMIT = DEN_W'(1) << (NUM_SHIFT - BETA_W);

   typedef struct packed {
      logic accept;
      logic sqrt_load;
      logic sqrt_step;
      logic den_load;
      logic div_step;
      logic out_load;
   } cmd_type;

endpackage

// File: rtl/hvg_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on hvg_pkg for field widths.
interface hvg_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hvg_pkg::ELEM_W-1:0]    element_value;
   logic                                 last_element;
   modport source (output valid, element_value, last_element, input ready);
   modport sink (input valid, element_value, last_element, output ready);
endinterface

interface hvg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [hvg_pkg::OUT_W-1:0]     new_pivot;
   logic        [hvg_pkg::BETA_W-1:0]    beta_out;
   logic signed [hvg_pkg::OUT_W-1:0]     phi_out;
   modport source (output valid, new_pivot, beta_out, phi_out, input ready);
   modport sink (input valid, new_pivot, beta_out, phi_out, output ready);
endinterface

// File: rtl/hvg_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the generator: accumulation, square root, multiply, divide
// and result hand-off. Depends on hvg_pkg.
module hvg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output hvg_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_ACCUM, ST_DRAIN, ST_LOAD, ST_SQRT, ST_MULT, ST_DIV, ST_FINISH
   } state_type;

   state_type                     state_ff, state_in;
   logic [hvg_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_ACCUM);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == ST_ACCUM) && req_valid;
      cmd.sqrt_load = (state_ff == ST_LOAD);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.den_load  = (state_ff == ST_MULT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.out_load  = (state_ff == ST_FINISH) && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_ACCUM: begin
            if (req_valid && req_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_LOAD;
         ST_LOAD: begin
            cnt_in   = hvg_pkg::CNT_W'(hvg_pkg::SQRT_STEPS - 1);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_MULT;
         end
         ST_MULT: begin
            cnt_in   = hvg_pkg::CNT_W'(hvg_pkg::DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/hvg_datapath.sv
`timescale 1ns / 1ps
// Datapath: squaring accumulator, digit-by-digit square root, denominator
// multiplier, restoring divider and result registers. Depends on hvg_pkg.
module hvg_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  hvg_pkg::cmd_type                    cmd,
   input  logic                                csr_write_en,
   input  logic        [hvg_pkg::THR_W-1:0]    csr_write_data,
   input  logic signed [hvg_pkg::ELEM_W-1:0]   req_element_value,
   input  logic                                req_last_element,
   output logic signed [hvg_pkg::OUT_W-1:0]    rsp_new_pivot,
   output logic        [hvg_pkg::BETA_W-1:0]   rsp_beta_out,
   output logic signed [hvg_pkg::OUT_W-1:0]    rsp_phi_out
);

   localparam int EW = hvg_pkg::ELEM_W;
   localparam int OW = hvg_pkg::OUT_W;
   localparam int RW = hvg_pkg::ROOT_W;

   logic [hvg_pkg::THR_W-1:0]   thr_ff;
   logic                        awaiting_ff;
   logic [EW-1:0]               pivot_ff;
   logic [hvg_pkg::SQ_W-1:0]    sq_ff;
   logic                        sq_valid_ff;
   logic [hvg_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [hvg_pkg::RAD_W-1:0]   rad_ff;
   logic [hvg_pkg::REM_W-1:0]   srem_ff;
   logic [RW-1:0]               root_ff;
   logic [hvg_pkg::DEN_W-1:0]   den_ff;
   logic [hvg_pkg::DEN_W-1:0]   drem_ff;
   logic                        num_ff;
   logic [hvg_pkg::BETA_W-1:0]  quot_ff;
   logic signed [OW-1:0]        new_pivot_ff, phi_ff;
   logic [hvg_pkg::BETA_W-1:0]  beta_ff;

   logic [EW-1:0]               elem_mag, pivot_mag;
   logic [hvg_pkg::SUM_W:0]     sum_wide;
   logic [hvg_pkg::REM_W+1:0]   srem_sh, s_trial;
   logic [hvg_pkg::APM_W-1:0]   alpha_pm;
   logic [hvg_pkg::DEN_W-1:0]   den_in;
   logic [hvg_pkg::DEN_W:0]     drem_sh, d_trial;
   logic [OW-1:0]               pivot_x, alpha_x;
   logic [hvg_pkg::BETA_W-1:0]  beta_in;

   assign elem_mag  = req_element_value[EW-1] ? (~req_element_value + 1'b1)
                                               : req_element_value;
   assign pivot_mag = pivot_ff[EW-1] ? (~pivot_ff + 1'b1) : pivot_ff;

   // saturate the running sum at its full width
   assign sum_wide = {1'b0, sum_ff} + (hvg_pkg::SUM_W + 1)'(sq_ff);
   always_comb begin
      sum_in = sum_ff;
      if (sq_valid_ff) begin
         sum_in = sum_wide[hvg_pkg::SUM_W] ? '1 : sum_wide[hvg_pkg::SUM_W-1:0];
      end
   end

   assign srem_sh = {srem_ff, rad_ff[hvg_pkg::RAD_W-1 -: 2]};
   assign s_trial = {1'b0, root_ff, 2'b01};

   assign alpha_pm = hvg_pkg::APM_W'(root_ff) + hvg_pkg::APM_W'(pivot_mag);
   assign den_in   = root_ff * alpha_pm;

   assign drem_sh = {drem_ff, num_ff};
   assign d_trial = {1'b0, den_ff};

   assign pivot_x = {{(OW-EW){pivot_ff[EW-1]}}, pivot_ff};
   assign alpha_x = OW'(root_ff);

   always_comb begin
      priority if ({3'b000, root_ff} < (RW + 3)'(thr_ff)) begin
         beta_in = '0;
      end else if (den_ff <= hvg_pkg::DEN_SAT_LIMIT) begin
         beta_in = '1;
      end else begin
         beta_in = quot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= hvg_pkg::THR_RESET;
         awaiting_ff <= 1'b1;
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         if (csr_write_en) thr_ff <= csr_write_data;
         sq_valid_ff <= cmd.accept;
         if (cmd.accept) awaiting_ff <= req_last_element;
         // hand the finished sum to the root unit and start afresh
         sum_ff <= cmd.sqrt_load ? '0 : sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sq_ff <= hvg_pkg::SQ_W'(elem_mag * elem_mag);
         if (awaiting_ff) pivot_ff <= req_element_value;
      end
      if (cmd.sqrt_load) begin
         rad_ff  <= {1'b0, sum_ff};
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= rad_ff << 2;
         if (srem_sh >= s_trial) begin
            srem_ff <= hvg_pkg::REM_W'(srem_sh - s_trial);
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            srem_ff <= hvg_pkg::REM_W'(srem_sh);
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
      if (cmd.den_load) begin
         den_ff  <= den_in;
         drem_ff <= '0;
         num_ff  <= 1'b1;
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= 1'b0;
         if (drem_sh >= d_trial) begin
            drem_ff <= hvg_pkg::DEN_W'(drem_sh - d_trial);
            quot_ff <= {quot_ff[hvg_pkg::BETA_W-2:0], 1'b1};
         end else begin
            drem_ff <= hvg_pkg::DEN_W'(drem_sh);
            quot_ff <= {quot_ff[hvg_pkg::BETA_W-2:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         beta_ff <= beta_in;
         if (pivot_ff[EW-1]) begin
            new_pivot_ff <= pivot_x - alpha_x;
            phi_ff       <= alpha_x;
         end else begin
            new_pivot_ff <= pivot_x + alpha_x;
            phi_ff       <= '0 - alpha_x;
         end
      end
   end

   assign rsp_new_pivot = new_pivot_ff;
   assign rsp_beta_out  = beta_ff;
   assign rsp_phi_out   = phi_ff;

endmodule

// File: rtl/householder_vector_generate_top.sv
`timescale 1ns / 1ps
// Top level of the Householder vector generator.
// Depends on hvg_pkg, hvg_stream_if, hvg_ctrl and hvg_datapath.
//
// Usage:
//   req   - valid/ready channel, one vector element (signed Q8.16) per request,
//           the first request of a run is the pivot, last_element closes it.
//   rsp   - valid/ready channel, one result per run: new pivot, beta (Q16.16,
//           saturating, zero below the threshold) and phi.
//   csr_* - write port for the zero-norm threshold (Q8.16); write only while idle.
// Throughput: one request per cycle while a run accumulates; the squarer is
//   registered ahead of the saturating adder.
// Sequence from the last request to rsp.valid: drain the squarer, load
//   the root unit, 27 root steps (two radicand bits each), a multiply for
//   alpha*(alpha+|pivot|), 49 restoring divide steps of 2^48 by that
//   product, then register the result.
// req.ready is low from the last request of a run until its result is
//   registered. The result register frees the core: a new run accumulates while
//   the previous result waits; a stalled receiver holds only the finish step.
// Reset: synchronous, active high; clears the sum, sets the threshold to one
//   LSB and arms pivot capture.
module householder_vector_generate_top (
   input  logic                           clock,
   input  logic                           reset,
   hvg_req_if.sink                        req,
   hvg_rsp_if.source                      rsp,
   input  logic                           csr_write_en,
   input  logic [hvg_pkg::THR_W-1:0]      csr_write_data
);

   hvg_pkg::cmd_type cmd;

   // sequencing and handshakes
   hvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_element),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .cmd       (cmd)
   );

   // arithmetic and result registers
   hvg_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_element_value (req.element_value),
      .req_last_element  (req.last_element),
      .rsp_new_pivot     (rsp.new_pivot),
      .rsp_beta_out      (rsp.beta_out),
      .rsp_phi_out       (rsp.phi_out)
   );

endmodule
